// ===== rtl/core/topk_pkg.sv =====
package topk_pkg;

  // Fixed field widths of the ports.
  localparam int KEY_W   = 32;
  localparam int TAG_W   = 16;
  localparam int LIMIT_W = 5;

  // Defaults for the top-level parameters.
  localparam int DEF_CAPACITY = 16;
  localparam int DEF_KEY_BITS = 32;

  // Limit register value after reset.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DRAIN  = 1'b1
  } action_e;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  // Per-cell control, driven by the top level in every cycle.
  typedef struct packed {
    logic ins_en;    // an insert writes the row in this cycle
    logic drain_en;  // the row shifts one place toward cell 0
    logic occ;       // cell holds an entry that takes part in the insert
    logic tail;      // first free place of the insert
  } cell_ctrl_t;

endpackage

// ===== rtl/core/topk_cell.sv =====
module topk_cell #(
  parameter int KEY_BITS = topk_pkg::DEF_KEY_BITS
) (
  input  logic                      clk_i,
  input  topk_pkg::cell_ctrl_t      ctrl_i,
  input  logic                      live_i,
  input  logic [KEY_BITS-1:0]       new_key_i,
  input  logic [topk_pkg::TAG_W-1:0] new_tag_i,
  input  logic [KEY_BITS-1:0]       left_key_i,
  input  logic [topk_pkg::TAG_W-1:0] left_tag_i,
  input  logic                      gt_left_i,
  input  logic [KEY_BITS-1:0]       right_key_i,
  input  logic [topk_pkg::TAG_W-1:0] right_tag_i,
  output logic [KEY_BITS-1:0]       key_o,
  output logic [topk_pkg::TAG_W-1:0] tag_o,
  output logic                      gt_o,
  output logic                      ge_o
);
  import topk_pkg::*;

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [TAG_W-1:0]    tag_q, tag_d;

  // The row is kept ascending, so the cells whose key is greater than the
  // new one form a contiguous run at the high end of the occupied range.
  assign gt_o = ctrl_i.occ && (key_q > new_key_i);
  assign ge_o = live_i && (key_q >= new_key_i);

  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    if (ctrl_i.drain_en) begin
      key_d = right_key_i;
      tag_d = right_tag_i;
    end else if (ctrl_i.ins_en) begin
      if (gt_left_i) begin
        key_d = left_key_i;
        tag_d = left_tag_i;
      end else if (gt_o || ctrl_i.tail) begin
        key_d = new_key_i;
        tag_d = new_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule

// ===== rtl/core/top_k_smallest_keeper_unit.sv =====
// Keeps the k smallest keyed items seen so far in a sorted row of CAPACITY
// cells, where k is the configuration register (0 acts as 1, values above
// CAPACITY act as CAPACITY). An accepted insert is written to the row and the
// block is ready for the next insert in the following cycle: every cell
// compares its key with the new one in parallel and, in the same cycle,
// either holds, takes its left neighbor's entry, or loads the new entry.
// Once k entries are held, a key no larger than the largest kept key evicts
// that largest entry (the newest of equal maxima goes), and a larger key is
// dropped. Equal keys stay in arrival order. A drain transaction empties the
// row through cell 0 into the output register, one entry per cycle while the
// output is taken, in ascending key order, with out_last_o marking the final
// one; a drain holds off the input channel until its last entry has moved
// out of the row, since the single shift path of the cell row moves one entry
// per cycle unless the output stalls. A drain of an empty store produces no
// output transaction. The limit register may be written at any time the
// block is idle; it is not applied to entries already held, so lowering it
// only stops further growth.
module top_k_smallest_keeper_unit #(
  parameter int CAPACITY = topk_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = topk_pkg::DEF_KEY_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [topk_pkg::LIMIT_W-1:0]  cfg_top_k_limit_i,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [topk_pkg::KEY_W-1:0]    new_key_i,
  input  logic [topk_pkg::TAG_W-1:0]    new_tag_i,
  // Output channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [topk_pkg::KEY_W-1:0]    out_key_o,
  output logic [topk_pkg::TAG_W-1:0]    out_tag_o,
  output logic                          out_last_o
);
  import topk_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  // Control state.
  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        rem_q, rem_d;
  logic [LIMIT_W-1:0]   limit_q;
  logic                 out_valid_q, out_valid_d;

  // Output payload.
  logic [KEY_W-1:0]     out_key_q;
  logic [TAG_W-1:0]     out_tag_q;
  logic                 out_last_q;

  // Cell row.
  logic [KEY_BITS-1:0]  cell_key [CAPACITY];
  logic [TAG_W-1:0]     cell_tag [CAPACITY];
  logic [CAPACITY-1:0]  gt_vec;
  logic [CAPACITY-1:0]  ge_vec;
  cell_ctrl_t           cell_ctrl [CAPACITY];

  logic [KEY_BITS-1:0]  new_key_m;
  logic [KEY_W-1:0]     head_key_w;

  logic in_fire;
  logic ins_fire;
  logic drain_fire;
  logic below_limit;
  logic room;
  logic any_ge;
  logic do_grow;
  logic do_drop;
  logic ins_en;
  logic pop;
  logic [CW-1:0] n_ins;

  // Keys are held at KEY_BITS and presented at the port width.
  if (KEY_BITS > KEY_W) begin : g_key_wide
    assign new_key_m  = {{(KEY_BITS - KEY_W){1'b0}}, new_key_i};
    assign head_key_w = cell_key[0][KEY_W-1:0];
  end else if (KEY_BITS == KEY_W) begin : g_key_same
    assign new_key_m  = new_key_i;
    assign head_key_w = cell_key[0];
  end else begin : g_key_narrow
    assign new_key_m  = new_key_i[KEY_BITS-1:0];
    assign head_key_w = {{(KEY_W - KEY_BITS){1'b0}}, cell_key[0]};
  end

  assign cfg_ready_o = 1'b1;

  assign in_fire    = in_valid_i && in_ready_o;
  assign ins_fire   = in_fire && (action_e'(action_i) == ACT_INSERT);
  assign drain_fire = in_fire && (action_e'(action_i) == ACT_DRAIN);

  // A limit of zero behaves as one; the capacity bound covers larger values.
  always_comb begin
    if (limit_q == '0) begin
      below_limit = (count_q == '0);
    end else begin
      below_limit = (32'(count_q) < 32'(limit_q));
    end
  end

  assign room    = below_limit && (32'(count_q) < CAPACITY);
  assign any_ge  = |ge_vec;
  assign do_grow = ins_fire && room;
  assign do_drop = ins_fire && !room && any_ge;
  assign ins_en  = do_grow || do_drop;

  // When the largest entry is evicted, the insert works on one entry less,
  // and the new item may land in the evicted place.
  assign n_ins = do_drop ? (count_q - CW'(1)) : count_q;

  // Handshake side of the state machine.
  always_comb begin
    in_ready_o = 1'b0;
    pop        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_DRAIN: begin
        pop = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
        pop        = 1'b0;
      end
    endcase
  end

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    rem_d   = rem_q;
    case (state_q)
      ST_IDLE: begin
        if (do_grow) begin
          count_d = count_q + CW'(1);
        end else if (drain_fire && (count_q != '0)) begin
          state_d = ST_DRAIN;
          rem_d   = count_q;
          count_d = '0;
        end
      end
      ST_DRAIN: begin
        if (pop) begin
          rem_d = rem_q - CW'(1);
          if (rem_q == CW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_top_k_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_key_q  <= head_key_w;
      out_tag_q  <= cell_tag[0];
      out_last_q <= (rem_q == CW'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_key_q;
  assign out_tag_o   = out_tag_q;
  assign out_last_o  = out_last_q;

  // The cell row: cell 0 holds the smallest key.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] left_key;
    logic [TAG_W-1:0]    left_tag;
    logic                gt_left;
    logic [KEY_BITS-1:0] right_key;
    logic [TAG_W-1:0]    right_tag;

    if (i == 0) begin : g_first
      assign left_key = new_key_m;
      assign left_tag = new_tag_i;
      assign gt_left  = 1'b0;
    end else begin : g_inner
      assign left_key = cell_key[i-1];
      assign left_tag = cell_tag[i-1];
      assign gt_left  = gt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_key = cell_key[i];
      assign right_tag = cell_tag[i];
    end else begin : g_mid
      assign right_key = cell_key[i+1];
      assign right_tag = cell_tag[i+1];
    end

    assign cell_ctrl[i].ins_en   = ins_en;
    assign cell_ctrl[i].drain_en = pop;
    assign cell_ctrl[i].occ      = (CW'(i) < n_ins);
    assign cell_ctrl[i].tail     = (CW'(i) == n_ins);

    topk_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[i]),
      .live_i     (CW'(i) < count_q),
      .new_key_i  (new_key_m),
      .new_tag_i  (new_tag_i),
      .left_key_i (left_key),
      .left_tag_i (left_tag),
      .gt_left_i  (gt_left),
      .right_key_i(right_key),
      .right_tag_i(right_tag),
      .key_o      (cell_key[i]),
      .tag_o      (cell_tag[i]),
      .gt_o       (gt_vec[i]),
      .ge_o       (ge_vec[i])
    );
  end

`ifndef SYNTH
  // The kept count never exceeds the row length.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CAPACITY)
    else $error("kept count above capacity");

  // While draining, entries remain and the store is already marked empty.
  a_drain_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> ((rem_q != '0) && (count_q == '0)))
    else $error("drain state inconsistent with counters");

  // The final entry of a drain run comes out marked as last.
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (rem_q == CW'(1))) |=> (out_valid_o && out_last_o && (state_q == ST_IDLE)))
    else $error("drain did not end with a last-marked transaction");

  // A growing insert adds exactly one entry.
  a_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_grow |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the store by one");

  // An eviction never happens while there is still room.
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_drop |-> (!room && (count_q != '0)))
    else $error("eviction with room left");
`endif

endmodule
